// ===== design/stack_bytecode_executor_top_assert.svh =====
// Assertion macros for the stack executor checker
`ifndef STACK_BYTECODE_EXECUTOR_TOP_ASSERT_SVH
`define STACK_BYTECODE_EXECUTOR_TOP_ASSERT_SVH
`define SBE_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define SBE_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/sbe_pkg.sv =====
`default_nettype none
package sbe_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned OpW = 8;
  localparam int unsigned StatusW = 3;

  typedef enum logic [OpW-1:0] {
    OP_HALT = 8'd0, OP_LIT = 8'd1, OP_ADD = 8'd2, OP_SUB = 8'd3, OP_MUL = 8'd4,
    OP_DIV = 8'd5, OP_MOD = 8'd6, OP_NEG = 8'd7, OP_NOT = 8'd8, OP_AND = 8'd9,
    OP_OR = 8'd10, OP_XOR = 8'd11, OP_SHL = 8'd12, OP_SHR = 8'd13
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK = 3'd0, ST_DIVZERO = 3'd1, ST_ILLEGAL = 3'd2, ST_UNDER = 3'd3,
    ST_OVER = 3'd4
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [DataW-1:0] literal;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]   value;
    logic [StatusW-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [OpW-1:0]   op;
    logic [DataW-1:0] l;
    logic [DataW-1:0] r;
  } alu_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] res;
  } alu_rsp_t;
endpackage
`default_nettype wire

// ===== design/sbe_if.sv =====
`default_nettype none
interface sbe_if #(
  parameter int unsigned W = 1
) (
  input wire logic clk_i
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/stack_bytecode_executor_top.sv =====
// Stack-machine bytecode executor.
// in_if (sink): one instruction per request, fields opcode and literal.
// out_if (source): one result per halt or fault, fields value and status.
// Literal pushes; other operations pop operands from the stack RAM (top
// held in a register) and push a result computed by one shared ALU.
// Unary and binary ops step through accept, one RAM read for the second
// operand, ALU start and writeback; div/mod also wait for the restoring
// divider. Literal completes at accept; halt and faults go to the result.
// ready is low while an instruction executes or a result waits.
// The result register holds value/status until out_if.ready; a stalled
// receiver blocks further requests. After any result the stack is empty.
// Reset: asynchronous, empties the stack; RAM contents are not cleared.
`default_nettype none
module stack_bytecode_executor_top #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sbe_if.sink       in_if,
  sbe_if.source     out_if
);
  import sbe_pkg::*;

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_RD = 5'b00010, S_GO = 5'b00100, S_WAIT = 5'b01000,
    S_OUT = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  depth_q, depth_d;
  logic [DataW-1:0] top_q, top_d, val_q, val_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [OpW-1:0]   op_q, op_d;
  req_t             req;
  logic             unary;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [DataW-1:0] wdata, rdata;
  alu_req_t         areq;
  alu_rsp_t         arsp;

  assign req = req_t'(in_if.data);
  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.data = {val_q, st_q};
  assign unary = (op_q == OP_NEG) || (op_q == OP_NOT);

  sbe_ram #(.Width(DataW), .Depth(STACK_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sbe_alu u_alu (.clk_i, .rst_ni, .req_i(areq), .rsp_o(arsp));

  always_comb begin
    state_d = state_q; depth_d = depth_q; top_d = top_q; val_d = val_q;
    st_d = st_q; op_d = op_q;
    we = 1'b0; waddr = AddrW'(depth_q - 1'b1); wdata = top_q;
    raddr = AddrW'(depth_q - 2'd2);
    areq.start = 1'b0; areq.op = op_q; areq.l = rdata; areq.r = top_q;
    unique case (state_q)
      S_IDLE: if (in_if.valid) begin
        op_d = req.opcode;
        if (req.opcode > OP_SHR) begin
          val_d = '0; st_d = ST_ILLEGAL; state_d = S_OUT;
        end else if (req.opcode == OP_LIT) begin
          if (depth_q == CntW'(STACK_DEPTH)) begin
            val_d = '0; st_d = ST_OVER; state_d = S_OUT;
          end else begin
            if (depth_q != '0) we = 1'b1;
            top_d = req.literal; depth_d = depth_q + 1'b1;
          end
        end else if (depth_q == '0 || (depth_q == CntW'(1) &&
                     !(req.opcode == OP_HALT || req.opcode == OP_NEG ||
                       req.opcode == OP_NOT))) begin
          val_d = '0; st_d = ST_UNDER; state_d = S_OUT;
        end else if (req.opcode == OP_HALT) begin
          val_d = top_q; st_d = ST_OK; state_d = S_OUT;
        end else if ((req.opcode == OP_DIV || req.opcode == OP_MOD) && top_q == '0) begin
          val_d = '0; st_d = ST_DIVZERO; state_d = S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_GO;
      S_GO: begin
        areq.start = 1'b1; state_d = S_WAIT;
      end
      S_WAIT: if (arsp.done) begin
        top_d = arsp.res;
        if (!unary) depth_d = depth_q - 1'b1;
        state_d = S_IDLE;
      end
      S_OUT: if (out_if.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE && state_d == S_OUT) depth_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; depth_q <= '0;
    end else begin
      state_q <= state_d; depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d; val_q <= val_d; st_q <= st_d; op_q <= op_d;
  end
endmodule
`default_nettype wire

// ===== design/sbe_ram.sv =====
`default_nettype none
module sbe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/sbe_alu.sv =====
`default_nettype none
module sbe_alu (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  sbe_pkg::alu_req_t     req_i,
  output sbe_pkg::alu_rsp_t     rsp_o
);
  import sbe_pkg::*;

  logic             busy_q, busy_d, done_q, done_d, is_div_q, is_div_d;
  logic             neg_q_q, neg_q_d, neg_r_q, neg_r_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DataW-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d, res_q, res_d;
  logic [DataW-1:0] ml, mr;
  logic [DataW:0]   trial;
  logic [DataW-1:0] rsh;
  logic [2*DataW-1:0] prod;

  assign ml = req_i.l[DataW-1] ? (~req_i.l + 1'b1) : req_i.l;
  assign mr = req_i.r[DataW-1] ? (~req_i.r + 1'b1) : req_i.r;
  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, dvs_q};
  assign prod = req_i.l * req_i.r;
  assign rsh = DataW'($signed(req_i.l) >>> req_i.r[4:0]);

  always_comb begin
    busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q;
    dvs_d = dvs_q; res_d = res_q; is_div_d = is_div_q;
    neg_q_d = neg_q_q; neg_r_d = neg_r_q;
    if (req_i.start) begin
      unique case (req_i.op)
        OP_DIV, OP_MOD: begin
          busy_d = 1'b1; cnt_d = 6'(DataW); quo_d = ml; rem_d = '0; dvs_d = mr;
          is_div_d = (req_i.op == OP_DIV);
          neg_q_d = req_i.l[DataW-1] ^ req_i.r[DataW-1];
          neg_r_d = req_i.l[DataW-1];
        end
        OP_ADD: begin res_d = req_i.l + req_i.r; done_d = 1'b1; end
        OP_SUB: begin res_d = req_i.l - req_i.r; done_d = 1'b1; end
        OP_MUL: begin res_d = prod[DataW-1:0]; done_d = 1'b1; end
        OP_NEG: begin res_d = ~req_i.r + 1'b1; done_d = 1'b1; end
        OP_NOT: begin res_d = ~req_i.r; done_d = 1'b1; end
        OP_AND: begin res_d = req_i.l & req_i.r; done_d = 1'b1; end
        OP_OR:  begin res_d = req_i.l | req_i.r; done_d = 1'b1; end
        OP_XOR: begin res_d = req_i.l ^ req_i.r; done_d = 1'b1; end
        OP_SHL: begin res_d = req_i.l << req_i.r[4:0]; done_d = 1'b1; end
        default: begin res_d = rsh; done_d = 1'b1; end
      endcase
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
        if (is_div_d) res_d = neg_q_q ? (~quo_d + 1'b1) : quo_d;
        else res_d = neg_r_q ? (~rem_d + 1'b1) : rem_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d; res_q <= res_d;
    is_div_q <= is_div_d; neg_q_q <= neg_q_d; neg_r_q <= neg_r_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res = res_q;
endmodule
`default_nettype wire

// ===== design/sbe_checker.sv =====
`default_nettype none
`include "stack_bytecode_executor_top_assert.svh"
module sbe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [34:0] out_data
);
  import sbe_pkg::*;
  `SBE_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, out_valid, !in_ready)
  `SBE_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid, out_data[2:0] <= ST_OVER)
  `SBE_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid && out_data[2:0] != ST_OK,
                  out_data[34:3] == '0)
  `SBE_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready,
                  out_valid && $stable(out_data))
endmodule

bind stack_bytecode_executor_top sbe_checker u_sbe_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire
